### rtl/sphere_pair_collision_projection_assert.svh
// assertion macros for the sphere pair collision projection block
`ifndef SPHERE_PAIR_COLLISION_PROJECTION_ASSERT_SVH
`define SPHERE_PAIR_COLLISION_PROJECTION_ASSERT_SVH

// condition implies consequence in the same cycle
`define PSC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psc assertion failed");

// condition implies consequence in the next cycle
`define PSC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psc assertion failed");

`endif

### rtl/psc_pkg.sv
// shared types, constants and helpers of the sphere pair collision projection
package psc_pkg;

	localparam int STEP_STAGES = 32;
	localparam int IN_W = 336;
	localparam int OUT_W = 224;

	typedef struct packed {
		logic [15:0]      idx_a;
		logic [15:0]      idx_b;
		logic [2:0][31:0] pa;
		logic [2:0][31:0] pb;
		logic [2:0]       neg;
		logic [2:0][31:0] mag;
		logic [31:0]      r;
		logic [23:0]      wa;
		logic [23:0]      wb;
		logic             hit;
		logic [31:0]      cdist;
		logic [31:0]      dlen;
		logic [2:0][31:0] disp;
	} item_t;

	function automatic logic [31:0] sat32(input logic [33:0] v);
		logic [31:0] res;
		if (!v[33] && v[32:31] != 2'b00) begin
			res = 32'h7fff_ffff;
		end else if (v[33] && v[32:31] != 2'b11) begin
			res = 32'h8000_0000;
		end else begin
			res = v[31:0];
		end
		return res;
	endfunction

endpackage

### rtl/psc_isqrt.sv
// pipelined integer square root, one result bit per stage
module psc_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] radicand,
	output logic [31:0] root
);

	logic [33:0] rem_s  [psc_pkg::STEP_STAGES];
	logic [31:0] root_s [psc_pkg::STEP_STAGES];
	logic [63:0] rest_s [psc_pkg::STEP_STAGES];

	logic [33:0] rem_i  [psc_pkg::STEP_STAGES];
	logic [31:0] root_i [psc_pkg::STEP_STAGES];
	logic [63:0] rest_i [psc_pkg::STEP_STAGES];
	logic [35:0] tr     [psc_pkg::STEP_STAGES];
	logic [35:0] tt     [psc_pkg::STEP_STAGES];

	always_comb begin
		for (int k = 0; k < psc_pkg::STEP_STAGES; k++) begin
			if (k == 0) begin
				rem_i[k]  = '0;
				root_i[k] = '0;
				rest_i[k] = radicand;
			end else begin
				rem_i[k]  = rem_s[k-1];
				root_i[k] = root_s[k-1];
				rest_i[k] = rest_s[k-1];
			end
			tr[k] = {rem_i[k], rest_i[k][63:62]};
			tt[k] = {2'b00, root_i[k], 2'b01};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < psc_pkg::STEP_STAGES; k++) begin
				rest_s[k] <= {rest_i[k][61:0], 2'b00};
				if (tr[k] >= tt[k]) begin
					rem_s[k]  <= 34'(tr[k] - tt[k]);
					root_s[k] <= {root_i[k][30:0], 1'b1};
				end else begin
					rem_s[k]  <= tr[k][33:0];
					root_s[k] <= {root_i[k][30:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[psc_pkg::STEP_STAGES-1];

endmodule

### rtl/psc_div.sv
// pipelined restoring divider, 64 by 32 bits, one quotient bit per stage
module psc_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quot
);

	logic [31:0] rem_s [psc_pkg::STEP_STAGES];
	logic [31:0] low_s [psc_pkg::STEP_STAGES];
	logic [31:0] dvs_s [psc_pkg::STEP_STAGES];
	logic [31:0] q_s   [psc_pkg::STEP_STAGES];

	logic [31:0] rem_i [psc_pkg::STEP_STAGES];
	logic [31:0] low_i [psc_pkg::STEP_STAGES];
	logic [31:0] dvs_i [psc_pkg::STEP_STAGES];
	logic [31:0] q_i   [psc_pkg::STEP_STAGES];
	logic [32:0] tr    [psc_pkg::STEP_STAGES];

	always_comb begin
		for (int k = 0; k < psc_pkg::STEP_STAGES; k++) begin
			if (k == 0) begin
				rem_i[k] = dividend[63:32];
				low_i[k] = dividend[31:0];
				dvs_i[k] = divisor;
				q_i[k]   = '0;
			end else begin
				rem_i[k] = rem_s[k-1];
				low_i[k] = low_s[k-1];
				dvs_i[k] = dvs_s[k-1];
				q_i[k]   = q_s[k-1];
			end
			tr[k] = {rem_i[k], low_i[k][31]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < psc_pkg::STEP_STAGES; k++) begin
				low_s[k] <= {low_i[k][30:0], 1'b0};
				dvs_s[k] <= dvs_i[k];
				if (tr[k] >= {1'b0, dvs_i[k]}) begin
					rem_s[k] <= 32'(tr[k] - {1'b0, dvs_i[k]});
					q_s[k]   <= {q_i[k][30:0], 1'b1};
				end else begin
					rem_s[k] <= tr[k][31:0];
					q_s[k]   <= {q_i[k][30:0], 1'b0};
				end
			end
		end
	end

	assign quot = q_s[psc_pkg::STEP_STAGES-1];

endmodule

### rtl/psc_delay.sv
// payload and valid delay line matching the square root and divider latency
module psc_delay (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              v_in,
	input  psc_pkg::item_t    d_in,
	output logic              v_out,
	output psc_pkg::item_t    d_out
);

	logic [psc_pkg::STEP_STAGES-1:0] v_s;
	psc_pkg::item_t                  d_s [psc_pkg::STEP_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[psc_pkg::STEP_STAGES-2:0], v_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= d_in;
			for (int k = 1; k < psc_pkg::STEP_STAGES; k++) begin
				d_s[k] <= d_s[k-1];
			end
		end
	end

	assign v_out = v_s[psc_pkg::STEP_STAGES-1];
	assign d_out = d_s[psc_pkg::STEP_STAGES-1];

endmodule

### rtl/sphere_pair_collision_projection.sv
// sphere pair collision projection, top level
// Takes one sphere pair per clock while the output is not stalled and returns one projected
// pair per pair taken, in order. The path runs through a 32 stage square root pipeline, two
// 32 stage divider pipelines (distance normalize and inverse-mass split), each one result
// bit per stage, and six arithmetic stages. All stages advance together whenever the output
// register is empty or its beat is taken, so a stalled output holds the whole pipeline
// without loss. Overlap is flagged on m_tuser[0].
`include "sphere_pair_collision_projection_assert.svh"

module sphere_pair_collision_projection (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// index_a, index_b, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
	// radius_a, radius_b, inv_mass_a, inv_mass_b, zero pad
	input  logic [psc_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// out_index_a, out_index_b, proj_a_x, proj_a_y, proj_a_z, proj_b_x, proj_b_y, proj_b_z
	output logic [psc_pkg::OUT_W-1:0]   m_tdata,
	// overlapping
	output logic [0:0]                  m_tuser
);

	logic en;

	psc_pkg::item_t   it_in, it2, it3, it4, it5;
	logic [2:0][32:0] dif, mag_in;
	logic [65:0]      sum66;

	logic             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	psc_pkg::item_t   it_s1, it_s2, it_s3, it_s4, it_s5;
	logic [2:0][32:0] mag_s1;
	logic [2:0][63:0] sq_s2;
	logic [63:0]      rsq_s2, sum_s3;
	logic [2:0][63:0] prod_s4;
	logic [5:0][63:0] prod_s5;
	logic [31:0]      wsum_s5;
	logic [5:0][31:0] proj_s6;
	logic [15:0]      idx_a_s6, idx_b_s6;
	logic             ovl_s6;

	logic             v_d0, v_d1, v_d2;
	psc_pkg::item_t   it_d0, it_d1, it_d2;
	logic [31:0]      root_w;
	logic [2:0][31:0] q1_w;
	logic [5:0][31:0] q2_w;

	logic [24:0]      wsum_d2;
	logic             move;
	logic [2:0][31:0] sa, sb;
	logic [2:0][33:0] sha, shb;
	logic [5:0][31:0] proj_d;

	assign en       = !v_s6 || m_tready;
	assign s_tready = en;

	// unpack, differences, radius sum
	always_comb begin
		it_in       = '0;
		it_in.idx_a = s_tdata[15:0];
		it_in.idx_b = s_tdata[31:16];
		it_in.r     = {1'b0, s_tdata[254:224]} + {1'b0, s_tdata[285:255]};
		it_in.wa    = s_tdata[309:286];
		it_in.wb    = s_tdata[333:310];
		for (int i = 0; i < 3; i++) begin
			it_in.pa[i]  = s_tdata[32+32*i +: 32];
			it_in.pb[i]  = s_tdata[128+32*i +: 32];
			dif[i]       = {it_in.pb[i][31], it_in.pb[i]} - {it_in.pa[i][31], it_in.pa[i]};
			it_in.neg[i] = dif[i][32];
			mag_in[i]    = dif[i][32] ? 33'(-dif[i]) : dif[i];
		end
	end

	// early reject and squares
	always_comb begin
		it2     = it_s1;
		it2.hit = 1'b1;
		for (int i = 0; i < 3; i++) begin
			it2.mag[i] = mag_s1[i][31:0];
			if (mag_s1[i] >= {1'b0, it_s1.r}) begin
				it2.hit = 1'b0;
			end
		end
	end

	// distance squared against radius squared
	always_comb begin
		sum66   = {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};
		it3     = it_s2;
		it3.hit = it_s2.hit && (sum66 < {2'b00, rsq_s2});
	end

	always_comb begin
		it4       = it_d0;
		it4.cdist = root_w;
		it4.dlen  = it_d0.r - root_w;
	end

	always_comb begin
		it5 = it_d1;
		for (int i = 0; i < 3; i++) begin
			if (it_d1.cdist == '0) begin
				it5.disp[i] = (i == 0) ? it_d1.dlen : '0;
			end else begin
				it5.disp[i] = q1_w[i];
			end
		end
	end

	// apply shifts with saturation
	always_comb begin
		wsum_d2 = {1'b0, it_d2.wa} + {1'b0, it_d2.wb};
		move    = it_d2.hit && (wsum_d2 != '0);
		for (int i = 0; i < 3; i++) begin
			sa[i]  = move ? q2_w[i] : '0;
			sb[i]  = move ? q2_w[3+i] : '0;
			sha[i] = it_d2.neg[i] ? 34'(-{2'b00, sa[i]}) : {2'b00, sa[i]};
			shb[i] = it_d2.neg[i] ? 34'(-{2'b00, sb[i]}) : {2'b00, sb[i]};
			proj_d[i]   = psc_pkg::sat32({{2{it_d2.pa[i][31]}}, it_d2.pa[i]} - sha[i]);
			proj_d[3+i] = psc_pkg::sat32({{2{it_d2.pb[i][31]}}, it_d2.pb[i]} + shb[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_d0;
			v_s5 <= v_d1;
			v_s6 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1   <= it_in;
			mag_s1  <= mag_in;
			it_s2   <= it2;
			rsq_s2  <= it_s1.r * it_s1.r;
			it_s3   <= it3;
			sum_s3  <= sum66[63:0];
			it_s4   <= it4;
			it_s5   <= it5;
			wsum_s5 <= {8'd0, 24'(0)} + 32'(it_d1.wa) + 32'(it_d1.wb);
			for (int i = 0; i < 3; i++) begin
				sq_s2[i]     <= mag_s1[i][31:0] * mag_s1[i][31:0];
				prod_s4[i]   <= it4.dlen * it_d0.mag[i];
				prod_s5[i]   <= it5.disp[i] * it_d1.wa;
				prod_s5[3+i] <= it5.disp[i] * it_d1.wb;
			end
			proj_s6  <= proj_d;
			idx_a_s6 <= it_d2.idx_a;
			idx_b_s6 <= it_d2.idx_b;
			ovl_s6   <= it_d2.hit;
		end
	end

	psc_isqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (sum_s3),
		.root     (root_w)
	);

	psc_delay u_dly0 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_s3),
		.d_in   (it_s3),
		.v_out  (v_d0),
		.d_out  (it_d0)
	);

	for (genvar i = 0; i < 3; i++) begin : g_norm
		psc_div u_div (
			.clk      (clk),
			.en       (en),
			.dividend (prod_s4[i]),
			.divisor  (it_s4.cdist),
			.quot     (q1_w[i])
		);
	end

	psc_delay u_dly1 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_s4),
		.d_in   (it_s4),
		.v_out  (v_d1),
		.d_out  (it_d1)
	);

	for (genvar i = 0; i < 6; i++) begin : g_split
		psc_div u_div (
			.clk      (clk),
			.en       (en),
			.dividend (prod_s5[i]),
			.divisor  (wsum_s5),
			.quot     (q2_w[i])
		);
	end

	psc_delay u_dly2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_s5),
		.d_in   (it_s5),
		.v_out  (v_d2),
		.d_out  (it_d2)
	);

	assign m_tvalid = v_s6;
	assign m_tdata  = {proj_s6, idx_b_s6, idx_a_s6};
	assign m_tuser  = ovl_s6;

	`PSC_ASSERT_IMP(a_dist_below_r, v_s4 && it_s4.hit, it_s4.cdist < it_s4.r)
	`PSC_ASSERT_IMP(a_disp_bound, v_s5 && it_s5.hit, it_s5.disp[0] <= it_s5.dlen)
	`PSC_ASSERT_IMP(a_zero_dist, v_s4 && it_s4.hit && it_s4.cdist == '0, it_s4.mag == '0)

endmodule

### sim/psc_checker.sv
// checker for the sphere pair collision projection: predicts each projected pair and compares
module psc_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [psc_pkg::IN_W-1:0]   s_tdata,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [psc_pkg::OUT_W-1:0]  m_tdata,
	input  logic [0:0]                 m_tuser,
	output int                         errors,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             hit;
		logic [psc_pkg::OUT_W-1:0] data;
	} proj_beat_t;

	proj_beat_t expected_proj[$];

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		logic [31:0] res;
		if (v > 64'sd2147483647)
			res = 32'h7fff_ffff;
		else if (v < -64'sd2147483648)
			res = 32'h8000_0000;
		else
			res = v[31:0];
		return res;
	endfunction

	function automatic proj_beat_t project_pair(input logic [psc_pkg::IN_W-1:0] din);
		proj_beat_t exp_beat;
		longint pa[3], pb[3], d[3], sha[3], shb[3];
		longint unsigned mag[3], disp[3], qa, qb;
		longint unsigned r, rsq, cdist, dlen, wa, wb, wsum;
		logic [65:0] sum;
		logic hit;
		r = 64'(din[254:224]) + 64'(din[285:255]);
		rsq = r * r;
		wa = 64'(din[309:286]);
		wb = 64'(din[333:310]);
		wsum = wa + wb;
		hit = 1'b1;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			pa[i] = longint'($signed(din[32 + 32*i +: 32]));
			pb[i] = longint'($signed(din[128 + 32*i +: 32]));
			d[i] = pb[i] - pa[i];
			mag[i] = d[i] < 0 ? longint'(-d[i]) : d[i];
			sha[i] = 0;
			shb[i] = 0;
			if (mag[i] >= r)
				hit = 1'b0;
		end
		if (hit) begin
			for (int i = 0; i < 3; i++)
				sum += 66'(mag[i] * mag[i]);
			if (sum[65:64] != 0 || sum[63:0] >= rsq)
				hit = 1'b0;
		end
		if (hit) begin
			cdist = int_sqrt(sum[63:0]);
			dlen = r - cdist;
			for (int i = 0; i < 3; i++) begin
				if (cdist > 0)
					disp[i] = (dlen * mag[i]) / cdist;
				else
					disp[i] = (i == 0) ? dlen : 0;
			end
			if (wsum != 0) begin
				for (int i = 0; i < 3; i++) begin
					qa = (disp[i] * wa) / wsum;
					qb = (disp[i] * wb) / wsum;
					sha[i] = d[i] < 0 ? -longint'(qa) : longint'(qa);
					shb[i] = d[i] < 0 ? -longint'(qb) : longint'(qb);
				end
			end
		end
		exp_beat.data[31:0] = din[31:0];
		for (int i = 0; i < 3; i++) begin
			exp_beat.data[32 + 32*i +: 32] = clamp32(pa[i] - sha[i]);
			exp_beat.data[128 + 32*i +: 32] = clamp32(pb[i] + shb[i]);
		end
		exp_beat.hit = hit;
		return exp_beat;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	string field_names[8] = '{"out_index_a", "out_index_b", "proj_a_x", "proj_a_y",
		"proj_a_z", "proj_b_x", "proj_b_y", "proj_b_z"};

	initial errors = 0;
	assign pending = expected_proj.size();

	always @(posedge clk) begin
		proj_beat_t head;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_proj.push_back(project_pair(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_proj.size() == 0) begin
					$display("%0t unexpected beat: expected none actual %h %h", $time,
						m_tdata, m_tuser);
					errors++;
				end else begin
					head = expected_proj.pop_front();
					compare_field(field_names[0], 32'(head.data[15:0]), 32'(m_tdata[15:0]));
					compare_field(field_names[1], 32'(head.data[31:16]), 32'(m_tdata[31:16]));
					for (int i = 2; i < 8; i++)
						compare_field(field_names[i], head.data[32*(i-1) +: 32],
							m_tdata[32*(i-1) +: 32]);
					compare_field("overlapping", 32'(head.hit), 32'(m_tuser[0]));
				end
			end
		end
	end
endmodule

### sim/tb_sphere_pair_collision_projection.sv
// testbench top for the sphere pair collision projection: stimulus, stalls and verdict
module tb_sphere_pair_collision_projection;
	timeunit 1ns;
	timeprecision 1ps;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [psc_pkg::IN_W-1:0]  s_tdata;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [psc_pkg::OUT_W-1:0] m_tdata;
	logic [0:0]                m_tuser;
	int errors, pending;
	int tx_idle, rx_idle;
	logic hold_req;
	int cycles;

	sphere_pair_collision_projection dut (.*);

	psc_checker chk (.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
		.m_tdata, .m_tuser, .errors, .pending);

	typedef struct {
		logic [15:0] ia, ib;
		logic [31:0] pa[3], pb[3];
		logic [30:0] ra, rb;
		logic [23:0] wa, wb;
	} pair_t;

	initial clk = 0;
	always #2 clk = ~clk;

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	function automatic logic [psc_pkg::IN_W-1:0] pack_pair(input pair_t p);
		return {2'b00, p.wb, p.wa, p.rb, p.ra, p.pb[2], p.pb[1], p.pb[0],
			p.pa[2], p.pa[1], p.pa[0], p.ib, p.ia};
	endfunction

	task automatic send_pair(input pair_t p);
		logic rdy;
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= pack_pair(p);
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
	endtask

	function automatic pair_t random_pair();
		pair_t p;
		int mode, k;
		longint dv;
		mode = $urandom_range(9);
		k = $urandom_range(2, 29);
		p.ia = 16'($urandom);
		p.ib = 16'($urandom);
		p.wa = ($urandom_range(9) == 0) ? 24'd0 : 24'($urandom);
		p.wb = ($urandom_range(9) == 0) ? 24'd0 : 24'($urandom);
		p.ra = 31'($urandom);
		p.rb = 31'($urandom);
		for (int i = 0; i < 3; i++) begin
			p.pa[i] = $urandom;
			p.pb[i] = $urandom;
		end
		if (mode < 7) begin
			// overlapping candidates at a random scale
			p.ra = 31'($urandom_range(0, 1 << k));
			p.rb = 31'($urandom_range(0, 1 << k));
			for (int i = 0; i < 3; i++) begin
				dv = longint'($urandom_range(0, 1 << k)) - (longint'(1) << (k - 1));
				p.pb[i] = p.pa[i] + 32'(dv);
			end
			if (mode == 6)
				p.pb = p.pa;
		end else if (mode == 7) begin
			// near the rails so the push saturates
			for (int i = 0; i < 3; i++) begin
				p.pa[i] = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(255)
					: 32'h7fff_ffff - $urandom_range(255);
				p.pb[i] = p.pa[i] + 32'($urandom_range(511)) - 32'd256;
			end
			p.ra = 31'(32'h7fff_ffff - $urandom_range(1000));
		end
		return p;
	endfunction

	task automatic run_random(input int n);
		repeat (n) send_pair(random_pair());
	endtask

	task automatic run_directed();
		pair_t p;
		p.ia = 0; p.ib = 0; p.ra = 0; p.rb = 0; p.wa = 0; p.wb = 0;
		for (int i = 0; i < 3; i++) begin
			p.pa[i] = 0;
			p.pb[i] = 0;
		end
		send_pair(p);                       // zero radius never overlaps
		p.ra = 31'h10000; p.wa = 24'h10000; p.wb = 24'h10000;
		send_pair(p);                       // coincident centres push along x
		p.wa = 0; p.wb = 0;
		send_pair(p);                       // both fixed
		p.wa = 24'hffffff; p.wb = 0; p.pb[1] = 32'h8000;
		send_pair(p);
		p.ia = 16'hffff; p.ib = 16'hffff; p.wa = 0; p.wb = 24'hffffff;
		p.pb[1] = 32'hffff_8000; p.pb[2] = 32'h4000;
		send_pair(p);
		p.pb[0] = 32'h10000; p.pb[1] = 0; p.pb[2] = 0;
		send_pair(p);                       // distance equals radius sum
		p.pb[0] = 32'hffff_0001;
		send_pair(p);
		p.ra = 31'h7fff_ffff; p.rb = 31'h7fff_ffff; p.wa = 24'hffffff; p.wb = 24'hffffff;
		for (int i = 0; i < 3; i++) begin
			p.pa[i] = 32'h7fff_ffff;
			p.pb[i] = 32'h8000_0000;
		end
		send_pair(p);                       // largest separation
		p.pb = p.pa;
		send_pair(p);                       // saturate high and low
		for (int i = 0; i < 3; i++) begin
			p.pa[i] = 32'h8000_0000;
			p.pb[i] = 32'h8000_0000 + 32'h100;
		end
		send_pair(p);
		p.pb[2] = 32'h7fff_ffff;
		send_pair(p);                       // one axis out of reach
		p.ra = 31'h4000_0000; p.rb = 31'h3fff_ffff;
		for (int i = 0; i < 3; i++) begin
			p.pa[i] = 32'hc000_0000;
			p.pb[i] = 32'h3fff_0000;
		end
		send_pair(p);                       // squared sum near the 64 bit limit
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		hold_req = 0;
		tx_idle = 0;
		rx_idle = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		run_directed();
		tx_idle = 24; rx_idle = 88;
		run_random(440);
		tx_idle = 88; rx_idle = 24;
		run_random(440);
		tx_idle = 0; rx_idle = 0;
		hold_req = 1;
		run_random(460);
		s_tvalid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

### sphere_pair_collision_projection.f
+incdir+rtl
rtl/psc_pkg.sv
rtl/psc_isqrt.sv
rtl/psc_div.sv
rtl/psc_delay.sv
rtl/sphere_pair_collision_projection.sv
sim/psc_checker.sv
sim/tb_sphere_pair_collision_projection.sv
